// ----- sv/xysc_pkg.sv -----
// Shared types and constants for the X/Y strip coincidence matcher.
package xysc_pkg;

  localparam int STRIP_COUNT = 16;

  localparam int TIME_W   = 48;
  localparam int GATE_W   = 20;
  localparam int ENERGY_W = 16;
  localparam int STRIP_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

  localparam logic [GATE_W-1:0]   GATE_RESET   = 20'd5000;
  localparam logic [ENERGY_W-1:0] THRESH_RESET = 16'd100;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]   hit_time;
    logic                axis;
    logic [STRIP_W-1:0]  strip;
    logic [ENERGY_W-1:0] energy;
  } hit_t;

  typedef struct packed {
    logic [STRIP_W-1:0]  x_strip;
    logic [STRIP_W-1:0]  y_strip;
    logic [ENERGY_W-1:0] x_energy;
    logic [ENERGY_W-1:0] y_energy;
    logic [GATE_W-1:0]   time_gap;
  } pair_t;

  typedef struct packed {
    logic [TIME_W-1:0]   time_ps;
    logic [STRIP_W-1:0]  strip;
    logic [ENERGY_W-1:0] energy;
  } entry_t;

endpackage

// ----- sv/xysc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module xysc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/xysc_fifo.sv -----
// Small register FIFO used for the command queue and the result queue.
module xysc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= ptr_inc(wp);
      end
      if (do_pop) begin
        rp <= ptr_inc(rp);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

// ----- sv/xysc_front.sv -----
// Front end: takes hits, drops low-energy and unmapped ones, queues the rest.
module xysc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  xysc_pkg::hit_t                       hit,
  input  logic [xysc_pkg::ENERGY_W-1:0]        energy_threshold,
  output logic                                 cmd_valid,
  output xysc_pkg::hit_t                       cmd,
  input  logic                                 cmd_pop
);

  logic keep;
  logic q_empty;

  assign keep = (hit.energy >= energy_threshold) &&
                (int'(hit.strip) < xysc_pkg::STRIP_COUNT);

  xysc_fifo #(
    .WIDTH($bits(xysc_pkg::hit_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (hit),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

// ----- sv/xysc_engine.sv -----
// Back end: prunes both buffers, searches the other plane, emits or appends.
module xysc_engine #(
  parameter int DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [xysc_pkg::GATE_W-1:0]   gate_ps,
  input  logic                          cmd_valid,
  input  xysc_pkg::hit_t                cmd,
  output logic                          cmd_pop,
  output logic                          res_push,
  output xysc_pkg::pair_t               res,
  input  logic                          res_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int TW = xysc_pkg::TIME_W;
  localparam int GW = xysc_pkg::GATE_W;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_PRUNE_RD  = 3'd1;
  localparam logic [2:0] ST_PRUNE_CHK = 3'd2;
  localparam logic [2:0] ST_SEARCH    = 3'd3;
  localparam logic [2:0] ST_DECIDE    = 3'd4;
  localparam logic [2:0] ST_SHIFT     = 3'd5;

  logic [2:0]  state;
  logic [AW-1:0] head [2];
  logic [AW-1:0] tail [2];
  logic [FW-1:0] fill [2];

  xysc_pkg::hit_t cur;
  logic [TW-1:0]  limit;
  logic           pax;
  logic           oax;
  logic [FW-1:0]  cnt;
  logic [AW-1:0]  ptr;
  logic [AW-1:0]  sdst;

  logic           rd_vld;
  logic [AW-1:0]  rd_ptr;
  logic [FW-1:0]  rd_k;

  logic           d_vld;
  logic [TW-1:0]  d_dt;
  logic [AW-1:0]  d_ptr;
  logic [FW-1:0]  d_k;
  logic [xysc_pkg::STRIP_W-1:0]  d_strip;
  logic [xysc_pkg::ENERGY_W-1:0] d_energy;

  logic           found;
  logic [AW-1:0]  best_ptr;
  logic [FW-1:0]  best_k;
  logic [GW-1:0]  best_dt;
  logic [xysc_pkg::STRIP_W-1:0]  best_strip;
  logic [xysc_pkg::ENERGY_W-1:0] best_energy;

  xysc_pkg::entry_t rdata [2];
  xysc_pkg::entry_t wdata [2];
  logic [AW-1:0]    raddr [2];
  logic [AW-1:0]    waddr [2];
  logic             we    [2];

  logic [TW-1:0]  gate_ext;
  logic [TW-1:0]  sdt;
  logic [TW-1:0]  ot;
  logic           better;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  xysc_ram #(.WIDTH($bits(xysc_pkg::entry_t)), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(we[0]), .waddr(waddr[0]), .wdata(wdata[0]),
    .raddr(raddr[0]), .rdata(rdata[0])
  );

  xysc_ram #(.WIDTH($bits(xysc_pkg::entry_t)), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(we[1]), .waddr(waddr[1]), .wdata(wdata[1]),
    .raddr(raddr[1]), .rdata(rdata[1])
  );

  assign oax      = ~cur.axis;
  assign gate_ext = {{(TW - GW){1'b0}}, gate_ps};
  assign ot       = rdata[oax].time_ps;
  assign sdt      = (ot > cur.hit_time) ? ot - cur.hit_time : cur.hit_time - ot;
  assign better   = d_vld && (d_dt[TW-1:GW] == '0) && (d_dt[GW-1:0] <= gate_ps) &&
                    (!found || (d_dt[GW-1:0] < best_dt));

  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign res_push = (state == ST_DECIDE) && found && !res_full;

  always_comb begin
    if (cur.axis == xysc_pkg::AXIS_Y) begin
      res.x_strip  = best_strip;
      res.y_strip  = cur.strip;
      res.x_energy = best_energy;
      res.y_energy = cur.energy;
    end else begin
      res.x_strip  = cur.strip;
      res.y_strip  = best_strip;
      res.x_energy = cur.energy;
      res.y_energy = best_energy;
    end
    res.time_gap = best_dt;
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      raddr[a] = '0;
      waddr[a] = '0;
      we[a]    = 1'b0;
      wdata[a] = '0;
    end
    case (state)
      ST_PRUNE_RD: begin
        raddr[pax] = head[pax];
      end
      ST_SEARCH: begin
        raddr[oax] = ptr;
      end
      ST_SHIFT: begin
        raddr[oax] = ptr;
        if (rd_vld) begin
          we[oax]    = 1'b1;
          waddr[oax] = rd_ptr;
          wdata[oax] = rdata[oax];
        end
      end
      ST_DECIDE: begin
        if (!found) begin
          we[cur.axis]    = 1'b1;
          waddr[cur.axis] = tail[cur.axis];
          wdata[cur.axis] = {cur.hit_time, cur.strip, cur.energy};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_vld  <= 1'b0;
      d_vld   <= 1'b0;
      found   <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        head[a] <= '0;
        tail[a] <= '0;
        fill[a] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          rd_vld <= 1'b0;
          d_vld  <= 1'b0;
          if (cmd_valid) begin
            cur   <= cmd;
            limit <= (cmd.hit_time > gate_ext) ? cmd.hit_time - gate_ext : '0;
            pax   <= xysc_pkg::AXIS_X;
            state <= ST_PRUNE_RD;
          end
        end
        ST_PRUNE_RD: begin
          if (fill[pax] == '0) begin
            if (pax == xysc_pkg::AXIS_Y) begin
              cnt   <= fill[oax];
              ptr   <= ptr_dec(tail[oax]);
              found <= 1'b0;
              state <= ST_SEARCH;
            end else begin
              pax <= xysc_pkg::AXIS_Y;
            end
          end else begin
            state <= ST_PRUNE_CHK;
          end
        end
        ST_PRUNE_CHK: begin
          if (rdata[pax].time_ps < limit) begin
            head[pax] <= ptr_inc(head[pax]);
            fill[pax] <= fill[pax] - FW'(1);
            state     <= ST_PRUNE_RD;
          end else if (pax == xysc_pkg::AXIS_Y) begin
            cnt   <= fill[oax];
            ptr   <= ptr_dec(tail[oax]);
            found <= 1'b0;
            state <= ST_SEARCH;
          end else begin
            pax   <= xysc_pkg::AXIS_Y;
            state <= ST_PRUNE_RD;
          end
        end
        ST_SEARCH: begin
          // read newest to oldest; strict compare keeps the newer entry on a tie
          if (cnt != '0) begin
            rd_vld <= 1'b1;
            rd_ptr <= ptr;
            rd_k   <= cnt - FW'(1);
            ptr    <= ptr_dec(ptr);
            cnt    <= cnt - FW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          d_vld    <= rd_vld;
          d_dt     <= sdt;
          d_ptr    <= rd_ptr;
          d_k      <= rd_k;
          d_strip  <= rdata[oax].strip;
          d_energy <= rdata[oax].energy;
          if (better) begin
            found       <= 1'b1;
            best_ptr    <= d_ptr;
            best_k      <= d_k;
            best_dt     <= d_dt[GW-1:0];
            best_strip  <= d_strip;
            best_energy <= d_energy;
          end
          if (cnt == '0 && !rd_vld && !d_vld) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (found) begin
            if (!res_full) begin
              ptr    <= ptr_inc(best_ptr);
              sdst   <= best_ptr;
              cnt    <= fill[oax] - FW'(1) - best_k;
              rd_vld <= 1'b0;
              state  <= ST_SHIFT;
            end
          end else begin
            tail[cur.axis] <= ptr_inc(tail[cur.axis]);
            if (fill[cur.axis] == FW'(DEPTH)) begin
              head[cur.axis] <= ptr_inc(head[cur.axis]);
            end else begin
              fill[cur.axis] <= fill[cur.axis] + FW'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_SHIFT: begin
          // close the gap left by the matched entry, one entry per cycle
          if (cnt != '0) begin
            rd_vld <= 1'b1;
            rd_ptr <= sdst;
            ptr    <= ptr_inc(ptr);
            sdst   <= ptr_inc(sdst);
            cnt    <= cnt - FW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (cnt == '0 && !rd_vld) begin
            fill[oax] <= fill[oax] - FW'(1);
            tail[oax] <= ptr_dec(tail[oax]);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/xy_strip_coincidence_matcher_core.sv -----
// Top level: X/Y strip coincidence matcher with config registers and queues.
// Engine steps per kept hit: take the command, prune each plane of entries older than the gate,
// search the other plane from newest to oldest, decide, and on a match close the gap behind it.
// The engine takes a new kept hit only once it is through with the last one; dropped hits go in
// one per cycle while the command queue has room. A pair shows in the result queue in the cycle
// after decide pushes it. Reset: fills 0, gate 5000, thr 100.
module xy_strip_coincidence_matcher_core #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // hit input queue
  input  logic                                   push,
  output logic                                   full,
  input  xysc_pkg::hit_t                         hit,
  // pair output queue
  output logic                                   empty,
  input  logic                                   pop,
  output xysc_pkg::pair_t                        pair,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [xysc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [xysc_pkg::GATE_W-1:0]            cfg_data
);

  logic [xysc_pkg::GATE_W-1:0]   gate_ps;
  logic [xysc_pkg::ENERGY_W-1:0] energy_threshold;

  logic            cmd_valid;
  logic            cmd_pop;
  xysc_pkg::hit_t  cmd;
  logic            res_push;
  logic            res_full;
  xysc_pkg::pair_t res;

  // Config is always writable; the sender must write only while no hit is in flight (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_ps          <= xysc_pkg::GATE_RESET;
      energy_threshold <= xysc_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xysc_pkg::CFG_GATE:   gate_ps <= cfg_data;
        xysc_pkg::CFG_THRESH: energy_threshold <= cfg_data[xysc_pkg::ENERGY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: filter and queue hits so the input keeps moving during a search.
  xysc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .hit              (hit),
    .energy_threshold (energy_threshold),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  // Back: prune, search, then emit a pair transaction or append the hit.
  xysc_engine #(
    .DEPTH(BUFFER_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .gate_ps   (gate_ps),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // Result queue decouples pair transactions from the consumer.
  xysc_fifo #(
    .WIDTH($bits(xysc_pkg::pair_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (pair),
    .empty (empty)
  );

endmodule
